### hw/rtl/mcc_pkg.sv
// ----------------------------------------------------------------------------
// mcc_pkg: shared types and codes for the modal compare counter
// Request/result payloads, register indexes, operation and mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

	localparam int CountWidth = 32;
	localparam int StepWidth  = 16;
	localparam int EvtWidth   = 16;
	localparam int CfgWidth   = 32;

	// register indexes
	localparam logic [1:0] RegReload    = 2'd0;
	localparam logic [1:0] RegCountDown = 2'd1;
	localparam logic [1:0] RegMode      = 2'd2;
	localparam logic [1:0] RegEventEn   = 2'd3;

	// operations
	localparam logic [1:0] OpTick    = 2'd0;
	localparam logic [1:0] OpCountBy = 2'd1;
	localparam logic [1:0] OpForce   = 2'd2;
	localparam logic [1:0] OpReset   = 2'd3;

	// modes
	localparam logic [1:0] ModeWrapped = 2'd0;
	localparam logic [1:0] ModeSingle  = 2'd1;
	localparam logic [1:0] ModeFree    = 2'd2;
	localparam logic [1:0] ModeLimited = 2'd3;

	typedef struct packed {
		logic [1:0]                  operation;
		logic signed [StepWidth-1:0] step_amount;
	} req_t;

	typedef struct packed {
		logic                  hit;
		logic [EvtWidth-1:0]   event_count;
		logic [CountWidth-1:0] count_value;
		logic                  running;
	} res_t;

	// configuration as seen by the step unit
	typedef struct packed {
		logic [CountWidth-1:0] reload_value;
		logic                  decrement;
		logic [1:0]            mode;
		logic                  event_enable;
	} step_cfg_t;

	// counter state before/after one step
	typedef struct packed {
		logic [CountWidth-1:0] count;
		logic                  enabled;
	} cnt_state_t;

	typedef struct packed {
		cnt_state_t nxt;
		logic       hit;
		logic       fire;
	} step_out_t;

endpackage

`default_nettype wire

### hw/rtl/mcc_step_unit.sv
// ----------------------------------------------------------------------------
// mcc_step_unit: one counter step with compare and mode action
// Adds +1/-1 (0 when disabled), compares with the target, applies the mode.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_step_unit (
	input  wire mcc_pkg::step_cfg_t  cfg,
	input  wire mcc_pkg::cnt_state_t cur,
	input  wire                      go_down,
	output mcc_pkg::step_out_t       res
);

	logic [mcc_pkg::CountWidth-1:0] delta;
	logic [mcc_pkg::CountWidth-1:0] sum;
	logic [mcc_pkg::CountWidth-1:0] target;

	always_comb begin
		if (!cur.enabled) begin
			delta = '0;
		end else if (go_down) begin
			delta = '1;
		end else begin
			delta = {{(mcc_pkg::CountWidth-1){1'b0}}, 1'b1};
		end
		sum    = cur.count + delta;
		target = cfg.decrement ? '0 : cfg.reload_value;

		res.nxt.count   = sum;
		res.nxt.enabled = cur.enabled;
		res.hit         = (sum == target);
		res.fire        = 1'b0;

		if (res.hit) begin
			case (cfg.mode)
				mcc_pkg::ModeWrapped: begin
					res.fire        = cfg.event_enable;
					res.nxt.enabled = 1'b1;
					res.nxt.count   = cfg.decrement ? cfg.reload_value : '0;
				end
				mcc_pkg::ModeSingle: begin
					res.fire        = cfg.event_enable & cur.enabled;
					res.nxt.enabled = 1'b0;
				end
				mcc_pkg::ModeFree: begin
					res.fire = cfg.event_enable;
				end
				default: begin
					// limited: back off, i.e. keep the pre-step count
					res.fire      = cfg.event_enable;
					res.nxt.count = cur.count;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/modal_compare_counter.sv
// ----------------------------------------------------------------------------
// modal_compare_counter: up/down compare counter with reload modes
// Sequencer around a single shared step unit; one request at a time.
// ----------------------------------------------------------------------------
// Sequencing: a request is taken only when the sequencer is idle. After the
// accept edge the block makes one pass through the shared step unit per
// counter step and then loads the result register: tick and force compare
// make one step, reset and count-by zero make none, and count-by n makes |n|
// steps (the most for n = -32768). The result register decouples the two
// sides: a new request may be accepted while the last result still waits,
// and the sequencer only stalls after its last step if that register is full.
// Register writes go straight to the config flops; mode, reload and target
// changes affect the next step, the step direction is taken at accept, and
// a write does not change the count; a reset request reloads it.
// ----------------------------------------------------------------------------
`default_nettype none

module modal_compare_counter (
	input  wire                           clk,
	input  wire                           arst_n,
	// config write port
	input  wire                           cfg_we,
	input  wire [1:0]                     cfg_index,
	input  wire [mcc_pkg::CfgWidth-1:0]   cfg_data,
	// request channel
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire mcc_pkg::req_t            in_data,
	// result channel
	output logic                          out_valid,
	input  wire                           out_ready,
	output mcc_pkg::res_t                 out_data
);

	localparam logic StIdle = 1'b0;
	localparam logic StRun  = 1'b1;

	logic                              state_q;

	// config registers
	mcc_pkg::step_cfg_t                cfg_q;

	// counter state
	mcc_pkg::cnt_state_t               cnt_q;
	logic [mcc_pkg::StepWidth-1:0]     steps_q;
	logic                              dir_down_q;
	logic                              hit_q;
	logic [mcc_pkg::EvtWidth-1:0]      events_q;

	// result register
	logic                              out_valid_q;
	mcc_pkg::res_t                     res_q;

	mcc_pkg::step_out_t                step;
	logic                              accept;
	logic                              finish;
	logic [mcc_pkg::StepWidth-1:0]     raw;
	logic [mcc_pkg::StepWidth-1:0]     mag;
	logic [mcc_pkg::CountWidth-1:0]    target;

	mcc_step_unit u_step (
		.cfg     (cfg_q),
		.cur     (cnt_q),
		.go_down (dir_down_q),
		.res     (step)
	);

	assign in_ready  = (state_q == StIdle);
	assign accept    = in_valid & in_ready;
	// done once all steps have gone and the result register is free
	assign finish    = (state_q == StRun) && (steps_q == '0) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	always_comb begin
		raw    = in_data.step_amount;
		// magnitude of a negative step count; -32768 stays 0x8000
		mag    = raw[mcc_pkg::StepWidth-1] ? (~raw + {{(mcc_pkg::StepWidth-1){1'b0}}, 1'b1})
		                                   : raw;
		target = cfg_q.decrement ? '0 : cfg_q.reload_value;
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mcc_pkg::RegReload:    cfg_q.reload_value <= cfg_data[mcc_pkg::CountWidth-1:0];
				mcc_pkg::RegCountDown: cfg_q.decrement    <= cfg_data[0];
				mcc_pkg::RegMode:      cfg_q.mode         <= cfg_data[1:0];
				mcc_pkg::RegEventEn:   cfg_q.event_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer and counter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= StIdle;
			cnt_q.count   <= '0;
			cnt_q.enabled <= 1'b1;
			steps_q       <= '0;
			dir_down_q    <= 1'b0;
			hit_q         <= 1'b0;
			events_q      <= '0;
		end else begin
			case (state_q)
				StIdle: begin
					if (accept) begin
						state_q    <= StRun;
						hit_q      <= 1'b0;
						events_q   <= '0;
						dir_down_q <= cfg_q.decrement;
						steps_q    <= '0;
						case (in_data.operation)
							mcc_pkg::OpTick: begin
								steps_q <= {{(mcc_pkg::StepWidth-1){1'b0}}, 1'b1};
							end
							mcc_pkg::OpCountBy: begin
								steps_q    <= mag;
								dir_down_q <= raw[mcc_pkg::StepWidth-1];
							end
							mcc_pkg::OpForce: begin
								// park one step short of the target, then tick
								steps_q     <= {{(mcc_pkg::StepWidth-1){1'b0}}, 1'b1};
								cnt_q.count <= cfg_q.decrement
									? target + {{(mcc_pkg::CountWidth-1){1'b0}}, 1'b1}
									: target - {{(mcc_pkg::CountWidth-1){1'b0}}, 1'b1};
							end
							default: begin
								cnt_q.enabled <= 1'b1;
								cnt_q.count   <= cfg_q.decrement ? cfg_q.reload_value : '0;
							end
						endcase
					end
				end
				default: begin
					if (steps_q != '0) begin
						cnt_q    <= step.nxt;
						steps_q  <= steps_q - {{(mcc_pkg::StepWidth-1){1'b0}}, 1'b1};
						hit_q    <= hit_q | step.hit;
						events_q <= events_q + {{(mcc_pkg::EvtWidth-1){1'b0}}, step.fire};
					end else if (finish) begin
						state_q <= StIdle;
					end
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			res_q.hit         <= hit_q;
			res_q.event_count <= events_q;
			res_q.count_value <= cnt_q.count;
			res_q.running     <= cnt_q.enabled;
		end
	end

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the modal compare counter
// Runs directed and random requests across register settings and predicts
// every result in-bench. Random gaps and stalls are applied on both handshakes.
// ----------------------------------------------------------------------------

module tb_top;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [1:0]                     cfg_index = mcc_pkg::RegReload;
	logic [mcc_pkg::CfgWidth-1:0]   cfg_data  = '0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	mcc_pkg::req_t                  in_data   = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	mcc_pkg::res_t                  out_data;

	// register mirror and counter state, both at their reset values
	mcc_pkg::step_cfg_t             cfg_mirror  = '0;
	logic [mcc_pkg::CountWidth-1:0] cnt_now     = '0;
	logic                           cnt_enabled = 1'b1;
	int unsigned                    evt_tally;

	mcc_pkg::req_t queued_reqs[$];   // requests not yet offered
	mcc_pkg::res_t due_results[$];   // predicted results, oldest first
	int     outstanding  = 0; // queued or in flight, result not yet seen
	int     mismatches   = 0;
	bit     no_idle      = 1'b0;
	longint cycle_budget = 0;
	longint cycles       = 0;
	int     hold_left    = 0;
	int     stall_left   = 0;
	int     stall_draw;
	mcc_pkg::res_t head_res;

	always #6 clk = ~clk;

	modal_compare_counter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// ------------------------------------------------------------------
	// Counter prediction
	// ------------------------------------------------------------------

	// up: compare against reload; down: compare against zero
	function automatic logic [mcc_pkg::CountWidth-1:0] compare_target();
		return cfg_mirror.decrement ? '0 : cfg_mirror.reload_value;
	endfunction

	function automatic void reload_count();
		cnt_enabled = 1'b1;
		cnt_now     = cfg_mirror.decrement ? cfg_mirror.reload_value : '0;
	endfunction

	// One counter step; returns 1 on a hit. A disabled counter adds zero
	// but still compares, which keeps a fired single-shot counter hitting.
	function automatic bit advance_one(bit go_down);
		logic [mcc_pkg::CountWidth-1:0] delta;
		delta = !cnt_enabled ? '0
			: (go_down ? '1 : {{(mcc_pkg::CountWidth-1){1'b0}}, 1'b1});
		cnt_now = cnt_now + delta;
		if (cnt_now != compare_target())
			return 1'b0;
		case (cfg_mirror.mode)
			mcc_pkg::ModeWrapped: begin
				if (cfg_mirror.event_enable) evt_tally++;
				reload_count();
			end
			mcc_pkg::ModeSingle: begin
				if (cnt_enabled && cfg_mirror.event_enable) evt_tally++;
				cnt_enabled = 1'b0;
			end
			mcc_pkg::ModeFree: begin
				if (cfg_mirror.event_enable) evt_tally++;
			end
			default: begin
				// limited: back off the step that reached the target
				cnt_now = cnt_now - delta;
				if (cfg_mirror.event_enable) evt_tally++;
			end
		endcase
		return 1'b1;
	endfunction

	function automatic mcc_pkg::res_t step_counter(mcc_pkg::req_t rq);
		mcc_pkg::res_t                  r;
		bit                             any_hit;
		bit                             neg;
		int                             steps;
		logic [mcc_pkg::CountWidth-1:0] tgt;
		evt_tally = 0;
		any_hit   = 1'b0;
		case (rq.operation)
			mcc_pkg::OpTick: begin
				any_hit = advance_one(cfg_mirror.decrement);
			end
			mcc_pkg::OpCountBy: begin
				// sign of the amount picks the direction, target stays put
				neg   = rq.step_amount < 0;
				steps = neg ? -int'(rq.step_amount) : int'(rq.step_amount);
				for (int i = 0; i < steps; i++)
					if (advance_one(neg)) any_hit = 1'b1;
			end
			mcc_pkg::OpForce: begin
				// park one step short of the target, then tick
				tgt     = compare_target();
				cnt_now = cfg_mirror.decrement ? tgt + 1'b1 : tgt - 1'b1;
				any_hit = advance_one(cfg_mirror.decrement);
			end
			default: begin
				reload_count();
			end
		endcase
		r.hit         = any_hit;
		r.event_count = evt_tally[mcc_pkg::EvtWidth-1:0];
		r.count_value = cnt_now;
		r.running     = cnt_enabled;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Helpers
	// ------------------------------------------------------------------

	// mostly short gaps, a few long ones; none while no_idle is set
	function automatic int draw_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %0h, got %0h", what, want, got);
	endfunction

	function automatic void queue_item(logic [1:0] op,
		logic signed [mcc_pkg::StepWidth-1:0] amt);
		mcc_pkg::req_t rq;
		int            mag;
		rq.operation   = op;
		rq.step_amount = amt;
		mag = amt;
		if (mag < 0) mag = -mag;
		queued_reqs.push_back(rq);
		outstanding++;
		// block cycles plus worst-case gap and stall for this request
		cycle_budget += 100 + ((op == mcc_pkg::OpCountBy) ? mag : 0);
	endfunction

	function automatic void queue_random_item();
		int                                   r;
		int                                   pick;
		logic [1:0]                           op;
		logic signed [mcc_pkg::StepWidth-1:0] amt;
		r = $urandom_range(0, 99);
		if (r < 30)      op = mcc_pkg::OpTick;
		else if (r < 70) op = mcc_pkg::OpCountBy;
		else if (r < 85) op = mcc_pkg::OpForce;
		else             op = mcc_pkg::OpReset;
		// small amounts keep count-by cheap; a few span the full range
		r = $urandom_range(0, 99);
		if (r < 88)      pick = $urandom_range(0, 80) - 40;
		else if (r < 97) pick = $urandom_range(0, 4000) - 2000;
		else             pick = $urandom_range(0, 65535);
		amt = pick[mcc_pkg::StepWidth-1:0];
		queue_item(op, amt);
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [mcc_pkg::CfgWidth-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			mcc_pkg::RegReload:    cfg_mirror.reload_value = val;
			mcc_pkg::RegCountDown: cfg_mirror.decrement    = val[0];
			mcc_pkg::RegMode:      cfg_mirror.mode         = val[1:0];
			default:               cfg_mirror.event_enable = val[0];
		endcase
	endtask

	task automatic apply_setting(logic [31:0] reload, bit down, logic [1:0] md, bit ev);
		write_reg(mcc_pkg::RegReload, reload);
		write_reg(mcc_pkg::RegCountDown, {{(mcc_pkg::CfgWidth-1){1'b0}}, down});
		write_reg(mcc_pkg::RegMode, {{(mcc_pkg::CfgWidth-2){1'b0}}, md});
		write_reg(mcc_pkg::RegEventEn, {{(mcc_pkg::CfgWidth-1){1'b0}}, ev});
	endtask

	// every request yields a result, so the last result means the block is idle
	task automatic drain();
		wait (outstanding == 0);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Request driver
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			in_data   <= '0;
			hold_left <= 0;
		end else begin
			if (in_valid && in_ready)
				due_results.push_back(step_counter(in_data));
			if (in_valid && !in_ready) begin
				// hold request until taken
			end else if (hold_left != 0) begin
				in_valid  <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (queued_reqs.size() != 0) begin
				in_valid  <= 1'b1;
				in_data   <= queued_reqs.pop_front();
				hold_left <= draw_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					flag_mismatch("result with no request pending", '0, '0);
				end else begin
					head_res = due_results.pop_front();
					outstanding--;
					if (out_data.hit !== head_res.hit)
						flag_mismatch("hit", head_res.hit, out_data.hit);
					if (out_data.event_count !== head_res.event_count)
						flag_mismatch("event_count", head_res.event_count,
							out_data.event_count);
					if (out_data.count_value !== head_res.count_value)
						flag_mismatch("count_value", head_res.count_value,
							out_data.count_value);
					if (out_data.running !== head_res.running)
						flag_mismatch("running", head_res.running, out_data.running);
				end
			end
			if (stall_left != 0) begin
				out_ready  <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				stall_draw = draw_gap();
				out_ready  <= (stall_draw == 0);
				stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	initial begin
		while (cycles < 4 * cycle_budget + 20000) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		logic [31:0] reload;
		int          r;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// wrapped, small target: reloads, force, back-stepping, zero count
		apply_setting(32'd5, 1'b0, mcc_pkg::ModeWrapped, 1'b1);
		queue_item(mcc_pkg::OpTick, 16'sd0);
		queue_item(mcc_pkg::OpTick, 16'sd0);
		queue_item(mcc_pkg::OpCountBy, 16'sd4);
		queue_item(mcc_pkg::OpTick, 16'sd0);
		queue_item(mcc_pkg::OpForce, 16'sd0);
		queue_item(mcc_pkg::OpCountBy, -16'sd3);
		queue_item(mcc_pkg::OpCountBy, 16'sd0);
		queue_item(mcc_pkg::OpReset, 16'sd0);
		drain();

		// single shot, down: positive count-by steps move away from zero, so nothing hits
		apply_setting(32'd3, 1'b1, mcc_pkg::ModeSingle, 1'b1);
		queue_item(mcc_pkg::OpReset, 16'sd0);
		queue_item(mcc_pkg::OpCountBy, 16'sd3);
		queue_item(mcc_pkg::OpTick, 16'sd0);
		queue_item(mcc_pkg::OpCountBy, 16'sd2);
		queue_item(mcc_pkg::OpReset, 16'sd0);
		drain();

		// free running at the top of the range
		apply_setting(32'hFFFF_FFFF, 1'b0, mcc_pkg::ModeFree, 1'b1);
		queue_item(mcc_pkg::OpForce, 16'sd0);
		queue_item(mcc_pkg::OpTick, 16'sd0);
		queue_item(mcc_pkg::OpCountBy, 16'sd300);
		drain();

		// limited with zero target upward: every step hits and backs off
		apply_setting(32'd0, 1'b0, mcc_pkg::ModeLimited, 1'b1);
		queue_item(mcc_pkg::OpForce, 16'sd0);
		queue_item(mcc_pkg::OpCountBy, 16'sh7FFF);
		drain();

		// same, downward, largest negative amount
		apply_setting(32'd0, 1'b1, mcc_pkg::ModeLimited, 1'b1);
		queue_item(mcc_pkg::OpReset, 16'sd0);
		queue_item(mcc_pkg::OpForce, 16'sd0);
		queue_item(mcc_pkg::OpCountBy, 16'sh8000);
		drain();

		// events off, down from the maximum reload
		apply_setting(32'hFFFF_FFFF, 1'b1, mcc_pkg::ModeWrapped, 1'b0);
		queue_item(mcc_pkg::OpReset, 16'sd0);
		queue_item(mcc_pkg::OpForce, 16'sd0);
		queue_item(mcc_pkg::OpTick, 16'sd0);
		queue_item(mcc_pkg::OpCountBy, -16'sd1);
		drain();

		// random phases: each mode twice, the count carries over between them
		for (int ph = 0; ph < 8; ph++) begin
			r = $urandom_range(0, 99);
			if (r < 60)      reload = $urandom_range(0, 40);
			else if (r < 75) reload = $urandom;
			else             reload = 32'hFFFF_FFFF - $urandom_range(0, 20);
			apply_setting(reload, $urandom_range(0, 1) != 0, ph[1:0],
				$urandom_range(0, 3) != 0);
			no_idle = (ph[1:0] == mcc_pkg::ModeFree);
			repeat ($urandom_range(8, 11)) queue_random_item();
			drain();
		end
		no_idle = 1'b0;

		repeat (40) @(posedge clk);
		if (mismatches == 0 && due_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
hw/rtl/mcc_pkg.sv
hw/rtl/mcc_step_unit.sv
hw/rtl/modal_compare_counter.sv
sim/tb_top.sv
